/* rtl/core/epoch_to_calendar_date_assert.svh */
// Assertion macros shared by the calendar conversion RTL.
`ifndef EPOCH_TO_CALENDAR_DATE_ASSERT_SVH
`define EPOCH_TO_CALENDAR_DATE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define E2CD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define E2CD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/e2cd_pkg.sv */
// Package with the types, constants and microcode table of the calendar converter.
package e2cd_pkg;

  localparam int unsigned STEP_W = 4;

  localparam logic [31:0] MAGIC_DIV60 = 32'h8888_8889;
  localparam logic [31:0] MAGIC_DIV24 = 32'hAAAA_AAAB;
  localparam int unsigned SHIFT_DIV60 = 37;
  localparam int unsigned SHIFT_DIV24 = 36;
  localparam logic [5:0]  DIVISOR_60 = 6'd60;
  localparam logic [5:0]  DIVISOR_24 = 6'd24;

  localparam logic [11:0] EPOCH_YEAR      = 12'd1970;
  localparam logic [1:0]  EPOCH_YEAR_MOD4 = 2'd2;
  localparam logic [6:0]  EPOCH_YEAR_MOD100 = 7'd70;
  localparam logic [8:0]  EPOCH_YEAR_MOD400 = 9'd370;
  localparam logic [6:0]  LAST_MOD100 = 7'd99;
  localparam logic [8:0]  LAST_MOD400 = 9'd399;
  localparam logic [8:0]  DAYS_LEAP_YEAR = 9'd366;
  localparam logic [8:0]  DAYS_COMMON_YEAR = 9'd365;
  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [11:0] LAST_YEAR = 12'd2106;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef enum logic [2:0] {
    OP_MUL,
    OP_DIV,
    OP_YEAR,
    OP_MONTH,
    OP_DONE
  } op_t;

  typedef enum logic [0:0] {
    DSEL_60,
    DSEL_24
  } dsel_t;

  typedef enum logic [1:0] {
    DST_SEC,
    DST_MIN,
    DST_HOUR
  } dst_t;

  typedef struct packed {
    op_t               op;
    dsel_t             dsel;
    dst_t              dst;
    logic [STEP_W-1:0] tgt;
  } ctrl_t;

  localparam logic [STEP_W-1:0] STEP_YEAR  = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_MONTH = STEP_W'(7);

  function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_t cw;
    cw = '{op: OP_DONE, dsel: DSEL_60, dst: DST_SEC, tgt: '0};
    case (step)
      STEP_W'(0): cw = '{op: OP_MUL,   dsel: DSEL_60, dst: DST_SEC,  tgt: '0};
      STEP_W'(1): cw = '{op: OP_DIV,   dsel: DSEL_60, dst: DST_SEC,  tgt: '0};
      STEP_W'(2): cw = '{op: OP_MUL,   dsel: DSEL_60, dst: DST_MIN,  tgt: '0};
      STEP_W'(3): cw = '{op: OP_DIV,   dsel: DSEL_60, dst: DST_MIN,  tgt: '0};
      STEP_W'(4): cw = '{op: OP_MUL,   dsel: DSEL_24, dst: DST_HOUR, tgt: '0};
      STEP_W'(5): cw = '{op: OP_DIV,   dsel: DSEL_24, dst: DST_HOUR, tgt: '0};
      STEP_W'(6): cw = '{op: OP_YEAR,  dsel: DSEL_60, dst: DST_SEC,  tgt: STEP_YEAR};
      STEP_W'(7): cw = '{op: OP_MONTH, dsel: DSEL_60, dst: DST_SEC,  tgt: STEP_MONTH};
      default:    cw = '{op: OP_DONE,  dsel: DSEL_60, dst: DST_SEC,  tgt: '0};
    endcase
    return cw;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* rtl/core/epoch_to_calendar_date.sv */
// Top level: microcoded converter from epoch seconds to calendar date and time.
//
//   Channel   Ports                          Handshake
//   input     in_epoch_seconds               start high while busy low
//   result    out_second_of_minute .. year   out_valid, one cycle, no stall
//
// An item walks 0 to 136 years and then 0 to 11 months by repeated subtraction
// between acceptance and the out_valid strobe.
// The year walk repeats one microcode step, which subtracts one year's length per pass.
// Reset returns the sequencer to idle; no result is pending after it.
// The receiver cannot stall; each result is shown for exactly one cycle.
`include "epoch_to_calendar_date_assert.svh"

module epoch_to_calendar_date (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  output logic [5:0]  out_second_of_minute,
  output logic [5:0]  out_minute_of_hour,
  output logic [4:0]  out_hour_of_day,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month_of_year,
  output logic [11:0] out_calendar_year
);

  e2cd_pkg::state_t state_r, state_nxt;
  logic [e2cd_pkg::STEP_W-1:0] step_r, step_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [31:0] acc_r, acc_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [11:0] year_r, year_nxt;
  logic [1:0]  ymod4_r, ymod4_nxt;
  logic [6:0]  ymod100_r, ymod100_nxt;
  logic [8:0]  ymod400_r, ymod400_nxt;

  e2cd_pkg::ctrl_t cw;
  logic [31:0] magic;
  logic [31:0] quo;
  logic [5:0]  divisor;
  logic [5:0]  rem;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic        accept;

  assign cw     = e2cd_pkg::ucode_rom(step_r);
  assign accept = start && (state_r == e2cd_pkg::ST_IDLE);
  assign leap   = (ymod4_r == 2'd0) &&
                  ((ymod100_r != 7'd0) || (ymod400_r == 9'd0));
  assign ylen   = leap ? e2cd_pkg::DAYS_LEAP_YEAR : e2cd_pkg::DAYS_COMMON_YEAR;
  assign mlen   = e2cd_pkg::month_len(month_r, leap);

  always_comb begin
    case (cw.dsel)
      e2cd_pkg::DSEL_24: begin
        magic   = e2cd_pkg::MAGIC_DIV24;
        quo     = 32'(prod_r >> e2cd_pkg::SHIFT_DIV24);
        divisor = e2cd_pkg::DIVISOR_24;
      end
      default: begin
        magic   = e2cd_pkg::MAGIC_DIV60;
        quo     = 32'(prod_r >> e2cd_pkg::SHIFT_DIV60);
        divisor = e2cd_pkg::DIVISOR_60;
      end
    endcase
    rem = 6'(acc_r - 32'(quo * {26'd0, divisor}));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      e2cd_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = e2cd_pkg::ST_RUN;
        end
      end
      e2cd_pkg::ST_RUN: begin
        if (cw.op == e2cd_pkg::OP_DONE) begin
          state_nxt = e2cd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = e2cd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      e2cd_pkg::ST_RUN: busy = 1'b1;
      default:          busy = 1'b0;
    endcase
  end

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    sec_nxt       = sec_r;
    min_nxt       = min_r;
    hour_nxt      = hour_r;
    day_nxt       = day_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    ymod4_nxt     = ymod4_r;
    ymod100_nxt   = ymod100_r;
    ymod400_nxt   = ymod400_r;
    if (state_r == e2cd_pkg::ST_IDLE) begin
      if (accept) begin
        acc_nxt  = in_epoch_seconds;
        step_nxt = '0;
      end
    end else begin
      case (cw.op)
        e2cd_pkg::OP_MUL: begin
          prod_nxt = {32'd0, acc_r} * {32'd0, magic};
          step_nxt = step_r + 1'b1;
        end
        e2cd_pkg::OP_DIV: begin
          acc_nxt = quo;
          case (cw.dst)
            e2cd_pkg::DST_MIN:  min_nxt = rem;
            e2cd_pkg::DST_HOUR: begin
              hour_nxt    = 5'(rem);
              year_nxt    = e2cd_pkg::EPOCH_YEAR;
              month_nxt   = e2cd_pkg::MONTH_JAN;
              ymod4_nxt   = e2cd_pkg::EPOCH_YEAR_MOD4;
              ymod100_nxt = e2cd_pkg::EPOCH_YEAR_MOD100;
              ymod400_nxt = e2cd_pkg::EPOCH_YEAR_MOD400;
            end
            default: sec_nxt = rem;
          endcase
          step_nxt = step_r + 1'b1;
        end
        e2cd_pkg::OP_YEAR: begin
          if (acc_r >= {23'd0, ylen}) begin
            acc_nxt     = acc_r - {23'd0, ylen};
            year_nxt    = year_r + 1'b1;
            ymod4_nxt   = ymod4_r + 1'b1;
            ymod100_nxt = (ymod100_r == e2cd_pkg::LAST_MOD100) ? 7'd0 : ymod100_r + 1'b1;
            ymod400_nxt = (ymod400_r == e2cd_pkg::LAST_MOD400) ? 9'd0 : ymod400_r + 1'b1;
            step_nxt    = cw.tgt;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
        e2cd_pkg::OP_MONTH: begin
          if ((month_r != e2cd_pkg::MONTH_DEC) && (acc_r >= {27'd0, mlen})) begin
            acc_nxt   = acc_r - {27'd0, mlen};
            month_nxt = month_r + 1'b1;
            step_nxt  = cw.tgt;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
        default: begin
          day_nxt       = 5'(acc_r) + 5'd1;
          out_valid_nxt = 1'b1;
          step_nxt      = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= e2cd_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    prod_r    <= prod_nxt;
    sec_r     <= sec_nxt;
    min_r     <= min_nxt;
    hour_r    <= hour_nxt;
    day_r     <= day_nxt;
    month_r   <= month_nxt;
    year_r    <= year_nxt;
    ymod4_r   <= ymod4_nxt;
    ymod100_r <= ymod100_nxt;
    ymod400_r <= ymod400_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_second_of_minute = sec_r;
  assign out_minute_of_hour   = min_r;
  assign out_hour_of_day      = hour_r;
  assign out_day_of_month     = day_r;
  assign out_month_of_year    = month_r;
  assign out_calendar_year    = year_r;

  `E2CD_ASSERT_NEXT(a_start_sets_busy, start && !busy, busy && !out_valid,
    "Accepted transaction did not start the sequencer.")
  `E2CD_ASSERT_NOW(a_result_when_idle, out_valid, !busy,
    "Result strobe while the sequencer is still running.")
  `E2CD_ASSERT_NOW(a_time_in_range, out_valid,
    (out_second_of_minute < 6'd60) && (out_minute_of_hour < 6'd60) &&
    (out_hour_of_day < 5'd24), "Time of day out of range.")
  `E2CD_ASSERT_NOW(a_month_in_range, busy && (cw.op == e2cd_pkg::OP_MONTH),
    (month_r >= e2cd_pkg::MONTH_JAN) && (month_r <= e2cd_pkg::MONTH_DEC),
    "Month walk left the year.")
  `E2CD_ASSERT_NOW(a_year_in_range, busy && (cw.op == e2cd_pkg::OP_YEAR),
    year_r <= e2cd_pkg::LAST_YEAR, "Year walk ran past the last representable year.")

endmodule
